// ===== design/csvt_pkg.sv =====
`timescale 1ns / 1ps
// csvt_pkg: shared types and constants of the CSV byte tokenizer.
// Depends on nothing; used by the channel interfaces and the tokenizer.
package csvt_pkg;

   localparam int BYTE_W   = 8;
   localparam int FIELD_W  = 10;
   localparam int ROW_W    = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;

   // Largest count the field counter can show
   localparam int FIELD_LIMIT = (1 << FIELD_W) - 1;
   localparam int MAX_FIELDS_DEFAULT = 1023;

   localparam logic [BYTE_W-1:0] CHR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHR_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;

   // Register indexes of the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_DELIMITER   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE_BYTE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_COUNT = 2'd2;

   typedef enum logic [2:0] {
      PH_BETWEEN = 3'd0,
      PH_FSTART  = 3'd1,
      PH_PLAIN   = 3'd2,
      PH_QUOTED  = 3'd3,
      PH_QSEEN   = 3'd4,
      PH_AFTERCR = 3'd5
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_PARSE    = 2'd1,
      ST_MISMATCH = 2'd2,
      ST_END      = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic               field_end;
      logic               row_end;
      logic [FIELD_W-1:0] fields_in_row;
      logic [ROW_W-1:0]   rows_done;
      status_type         status;
   } token_type;

endpackage

// ===== design/csvt_ifs.sv =====
`timescale 1ns / 1ps
// csvt_ifs: valid/ready channel interfaces of the CSV byte tokenizer.
// Depends on csvt_pkg for field widths.
interface csvt_req_if;
   import csvt_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_data;
   modport source (output valid, in_byte, end_of_data, input ready);
   modport sink   (input valid, in_byte, end_of_data, output ready);
endinterface

interface csvt_rsp_if;
   import csvt_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                byte_valid;
   logic                field_end;
   logic                row_end;
   logic [FIELD_W-1:0]  fields_in_row;
   logic [ROW_W-1:0]    rows_done;
   logic [STATUS_W-1:0] status;
   modport source (output valid, out_byte, byte_valid, field_end, row_end, fields_in_row,
                   rows_done, status, input ready);
   modport sink   (input valid, out_byte, byte_valid, field_end, row_end, fields_in_row,
                   rows_done, status, output ready);
endinterface

interface csvt_csr_if;
   import csvt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/csv_byte_tokenizer.sv =====
`timescale 1ns / 1ps
// csv_byte_tokenizer: CSV tokenizer, one byte or end-of-data mark per beat.
// Depends on csvt_pkg and the channel interfaces in csvt_ifs.
//
// Usage:
//  - req_if carries one beat per stream byte (in_byte) or an end-of-data mark
//    (end_of_data = 1, in_byte ignored). Every request beat gives exactly one
//    response beat on rsp_if, in order.
//  - rsp_if carries the content byte (when byte_valid), field_end and row_end
//    marks, the field count of the current row, rows done and a status
//    (ok, parse error, field count mismatch, end of data).
//  - csr_if writes delimiter (index 0), quote byte (1) and check_count (2).
//    It is always ready; write only while no request beat is in flight.
//  - Timing: a request beat accepted on req_if is held in the input register;
//    once the response register is free, the beat is parsed and its response
//    registered there, and rsp_if shows it until taken. Throughput is one beat
//    per cycle while rsp_if does not stall; the phase update between the two registers is
//    combinational compare-and-select logic plus the field and row counter increments.
//  - When rsp_if stalls, the response register holds and the input register
//    still takes one more beat; req_if.ready drops only when both are full.
//  - Synchronous reset returns to "between rows" with all counters zero, the
//    registers to comma, double quote and check off, and both stages empty.
//    After an end-of-data beat every later beat reports end of data until reset.
module csv_byte_tokenizer #(
   parameter int MAX_FIELDS = csvt_pkg::MAX_FIELDS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   csvt_req_if.sink   req_if,
   csvt_rsp_if.source rsp_if,
   csvt_csr_if.sink   csr_if
);
   import csvt_pkg::*;

   // Saturation point of the field counter
   localparam int FIELD_CAP_INT = (MAX_FIELDS < FIELD_LIMIT) ? MAX_FIELDS : FIELD_LIMIT;
   localparam logic [FIELD_W-1:0] FIELD_CAP = FIELD_W'(FIELD_CAP_INT);

   // ---------------- configuration registers ----------------
   logic [BYTE_W-1:0] delim_ff;
   logic [BYTE_W-1:0] quote_ff;
   logic              check_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= CHR_COMMA;
         quote_ff <= CHR_QUOTE;
         check_ff <= 1'b0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_DELIMITER:   delim_ff <= csr_if.data;
            CSR_QUOTE_BYTE:  quote_ff <= csr_if.data;
            CSR_CHECK_COUNT: check_ff <= csr_if.data[0];
            default: ;  // unused index: drop the write
         endcase
      end
   end

   // ---------------- pipeline handshake ----------------
   logic              in_vld_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_eod_ff;
   logic              rsp_vld_ff;
   token_type         rsp_ff;
   token_type         rsp_in;

   logic rsp_free;
   logic step;

   // Response register can take a beat when empty or being drained
   assign rsp_free     = !rsp_vld_ff || rsp_if.ready;
   // Process the held input beat this cycle
   assign step         = in_vld_ff && rsp_free;
   assign req_if.ready = !in_vld_ff || rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.in_byte;
         in_eod_ff  <= req_if.end_of_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid         = rsp_vld_ff;
   assign rsp_if.out_byte      = rsp_ff.out_byte;
   assign rsp_if.byte_valid    = rsp_ff.byte_valid;
   assign rsp_if.field_end     = rsp_ff.field_end;
   assign rsp_if.row_end       = rsp_ff.row_end;
   assign rsp_if.fields_in_row = rsp_ff.fields_in_row;
   assign rsp_if.rows_done     = rsp_ff.rows_done;
   assign rsp_if.status        = rsp_ff.status;

   // ---------------- parser state ----------------
   phase_type          phase_ff, phase_in;
   logic [FIELD_W-1:0] fld_cnt_ff, fld_cnt_in;
   logic [FIELD_W-1:0] exp_cnt_ff, exp_cnt_in;
   logic [ROW_W-1:0]   row_cnt_ff, row_cnt_in;
   logic               ended_ff, ended_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_BETWEEN;
         fld_cnt_ff <= '0;
         exp_cnt_ff <= '0;
         row_cnt_ff <= '0;
         ended_ff   <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         fld_cnt_ff <= fld_cnt_in;
         exp_cnt_ff <= exp_cnt_in;
         row_cnt_ff <= row_cnt_in;
         ended_ff   <= ended_in;
      end
   end

   // ---------------- next state and response ----------------
   always_comb begin
      logic       lf_absorbed;
      logic       take_byte;
      logic       take_end;
      logic       fld_close;
      logic       row_close;
      logic       perr;
      phase_type  p;
      logic [FIELD_W-1:0] fc;

      lf_absorbed = 1'b0;
      take_byte   = 1'b0;
      take_end    = 1'b0;
      fld_close   = 1'b0;
      row_close   = 1'b0;
      perr        = 1'b0;
      p           = phase_ff;
      fc          = fld_cnt_ff;

      rsp_in            = '0;
      rsp_in.status     = ST_OK;
      phase_in          = phase_ff;
      exp_cnt_in        = exp_cnt_ff;
      row_cnt_in        = row_cnt_ff;
      ended_in          = ended_ff;

      if (ended_ff) begin
         // stream is over: ignore the beat
         rsp_in.status = ST_END;
      end else begin
         // LF right after CR belongs to the same break
         if (phase_ff == PH_AFTERCR) begin
            p = PH_BETWEEN;
            lf_absorbed = !in_eod_ff && (in_byte_ff == CHR_LF);
         end
         if (!lf_absorbed) begin
            case (p)
               PH_FSTART, PH_PLAIN, PH_QUOTED, PH_QSEEN: begin
                  take_end  = in_eod_ff;
                  take_byte = !in_eod_ff;
               end
               default: begin
                  // between rows (and stray codes)
                  p = PH_BETWEEN;
                  if (in_eod_ff) begin
                     ended_in      = 1'b1;
                     rsp_in.status = ST_END;
                  end else begin
                     fc        = '0;
                     p         = PH_FSTART;
                     take_byte = 1'b1;
                  end
               end
            endcase
         end

         if (take_byte) begin
            if (in_byte_ff == delim_ff) begin
               if (p == PH_QUOTED) begin
                  rsp_in.byte_valid = 1'b1;
               end else begin
                  fld_close = 1'b1;
                  p = PH_FSTART;
               end
            end else if (in_byte_ff == quote_ff) begin
               case (p)
                  PH_FSTART: p = PH_QUOTED;
                  PH_PLAIN:  perr = 1'b1;
                  PH_QUOTED: p = PH_QSEEN;
                  default: begin
                     // doubled quote: pass one quote, stay quoted
                     rsp_in.byte_valid = 1'b1;
                     p = PH_QUOTED;
                  end
               endcase
            end else if (in_byte_ff == CHR_CR || in_byte_ff == CHR_LF) begin
               if (p == PH_QUOTED) begin
                  rsp_in.byte_valid = 1'b1;
               end else begin
                  fld_close = 1'b1;
                  row_close = 1'b1;
                  p = (in_byte_ff == CHR_CR) ? PH_AFTERCR : PH_BETWEEN;
               end
            end else begin
               if (p == PH_QSEEN) begin
                  perr = 1'b1;
               end else begin
                  rsp_in.byte_valid = 1'b1;
                  if (p == PH_FSTART) p = PH_PLAIN;
               end
            end
         end

         if (take_end) begin
            ended_in = 1'b1;
            if (p == PH_QUOTED) begin
               perr = 1'b1;
            end else begin
               fld_close = 1'b1;
               row_close = 1'b1;
               p = PH_BETWEEN;
            end
         end

         if (perr) begin
            rsp_in.status = ST_PARSE;
            p = PH_BETWEEN;
         end

         if (fld_close) begin
            rsp_in.field_end = 1'b1;
            if (fc < FIELD_CAP) fc = fc + 1'b1;
         end

         if (row_close) begin
            rsp_in.row_end = 1'b1;
            if (row_cnt_ff == '0) begin
               exp_cnt_in = fc;
            end else if (check_ff && (fc != exp_cnt_ff)) begin
               rsp_in.status = ST_MISMATCH;
            end
            row_cnt_in = row_cnt_ff + 1'b1;
         end
      end

      phase_in   = p;
      fld_cnt_in = fc;

      rsp_in.out_byte      = rsp_in.byte_valid ? in_byte_ff : '0;
      rsp_in.fields_in_row = fc;
      rsp_in.rows_done     = row_cnt_in;
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for csv_byte_tokenizer. It drives byte and end-of-data
// beats, predicts each response beat and compares it field by field.
// Depends on csvt_pkg, the channel interfaces in csvt_ifs and the tokenizer itself.
module tb;
   import csvt_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 10;
   localparam int MAX_GAP        = 19;
   localparam int DRAIN_CYCLES   = 4;     // two-stage pipe plus margin
   localparam int HOLD_CYCLES    = 120;   // long receiver stall in the backpressure test
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int FIELD_CAP = (MAX_FIELDS_DEFAULT < FIELD_LIMIT) ? MAX_FIELDS_DEFAULT
                                                                 : FIELD_LIMIT;

   localparam logic [BYTE_W-1:0] CHR_TAB  = 8'h09;
   localparam logic [BYTE_W-1:0] CHR_APOS = 8'h27;
   localparam logic [BYTE_W-1:0] CHR_SEMI = 8'h3B;
   localparam logic [BYTE_W-1:0] CHR_PIPE = 8'h7C;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csvt_req_if req_bus();
   csvt_rsp_if rsp_bus();
   csvt_csr_if csr_bus();

   csv_byte_tokenizer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------------
   // Tokenizer prediction: own copy of the registers and of the parse state.
   // Values start at the reset state; reset is applied only once.
   // ---------------------------------------------------------------------------
   logic [BYTE_W-1:0]  cfg_delim = CHR_COMMA;
   logic [BYTE_W-1:0]  cfg_quote = CHR_QUOTE;
   logic               cfg_check = 1'b0;

   phase_type          rx_phase     = PH_BETWEEN;
   logic [FIELD_W-1:0] fld_cnt      = '0;
   logic [FIELD_W-1:0] fld_expected = '0;
   logic [ROW_W-1:0]   row_cnt      = '0;
   bit                 ended        = 1'b0;

   token_type tk;                 // response beat under construction
   token_type expected_tokens[$]; // predicted beats, oldest first
   token_type rsp_want;

   int  beats_sent      = 0;
   int  rsp_beat        = 0;
   int  mismatch_count  = 0;
   int  idle_cycles     = 0;
   int  rsp_hold_cycles = 0;      // set by a test, picked up by the receiver
   bit  no_idle         = 1'b0;   // both sides run back to back while set

   function automatic void mark_field_end();
      tk.field_end = 1'b1;
      if (fld_cnt < FIELD_CAP) fld_cnt++;
   endfunction

   function automatic void mark_row_end();
      tk.row_end = 1'b1;
      // the first completed row (again after a wrap) learns the width
      if (row_cnt == '0) fld_expected = fld_cnt;
      else if (cfg_check && fld_cnt != fld_expected) tk.status = ST_MISMATCH;
      row_cnt++;
   endfunction

   // One byte while a row is open. Delimiter outranks quote, quote outranks CR/LF.
   function automatic void take_char(input logic [BYTE_W-1:0] c);
      if (c == cfg_delim) begin
         if (rx_phase == PH_QUOTED) begin
            tk.out_byte   = c;
            tk.byte_valid = 1'b1;
         end else begin
            mark_field_end();
            rx_phase = PH_FSTART;
         end
      end else if (c == cfg_quote) begin
         case (rx_phase)
            PH_FSTART: rx_phase = PH_QUOTED;
            PH_PLAIN: begin
               // quote inside an unquoted field
               tk.status = ST_PARSE;
               rx_phase  = PH_BETWEEN;
            end
            PH_QUOTED: rx_phase = PH_QSEEN;
            default: begin
               // doubled quote gives one quote byte
               tk.out_byte   = c;
               tk.byte_valid = 1'b1;
               rx_phase      = PH_QUOTED;
            end
         endcase
      end else if (c == CHR_CR || c == CHR_LF) begin
         if (rx_phase == PH_QUOTED) begin
            tk.out_byte   = c;
            tk.byte_valid = 1'b1;
         end else begin
            mark_field_end();
            mark_row_end();
            rx_phase = (c == CHR_CR) ? PH_AFTERCR : PH_BETWEEN;
         end
      end else if (rx_phase == PH_QSEEN) begin
         // plain byte right after a closing quote
         tk.status = ST_PARSE;
         rx_phase  = PH_BETWEEN;
      end else begin
         tk.out_byte   = c;
         tk.byte_valid = 1'b1;
         if (rx_phase == PH_FSTART) rx_phase = PH_PLAIN;
      end
   endfunction

   function automatic token_type tokenize(input logic [BYTE_W-1:0] c, input logic eod);
      bit absorbed;
      tk       = '0;
      absorbed = 1'b0;
      if (ended) begin
         tk.status = ST_END;
      end else begin
         if (rx_phase == PH_AFTERCR) begin
            rx_phase = PH_BETWEEN;
            absorbed = !eod && c == CHR_LF;   // CR LF is one break
         end
         if (!absorbed) begin
            if (rx_phase == PH_BETWEEN) begin
               if (eod) begin
                  ended     = 1'b1;
                  tk.status = ST_END;
               end else begin
                  fld_cnt  = '0;
                  rx_phase = PH_FSTART;
                  take_char(c);
               end
            end else if (eod) begin
               ended = 1'b1;
               if (rx_phase == PH_QUOTED) begin
                  tk.status = ST_PARSE;
               end else begin
                  mark_field_end();
                  mark_row_end();
               end
               rx_phase = PH_BETWEEN;
            end else begin
               take_char(c);
            end
         end
      end
      tk.fields_in_row = fld_cnt;
      tk.rows_done     = row_cnt;
      return tk;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side. Drive at the falling edge, see the handshake at the rising
   // edge. Valid stays high across back-to-back beats; drop it only for a gap.
   // ---------------------------------------------------------------------------
   task automatic send_beat(input logic [BYTE_W-1:0] b, input logic eod);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.in_byte     <= b;
      req_bus.end_of_data <= eod;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_tokens.push_back(tokenize(b, eod));
      beats_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_beat(text[i], 1'b0);
   endtask

   // Drop valid and hold until every predicted beat has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_DELIMITER:   cfg_delim = value;
         CSR_QUOTE_BYTE:  cfg_quote = value;
         CSR_CHECK_COUNT: cfg_check = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Registers change only with the pipe empty.
   task automatic apply_setting(input logic [BYTE_W-1:0] delim, input logic [BYTE_W-1:0] quote,
                                input logic check);
      wait_drained();
      write_reg(CSR_DELIMITER, delim);
      write_reg(CSR_QUOTE_BYTE, quote);
      write_reg(CSR_CHECK_COUNT, {7'd0, check});
   endtask

   // Random byte biased toward the bytes that steer the parser.
   function automatic logic [BYTE_W-1:0] any_byte();
      case ($urandom_range(0, 7))
         0: return cfg_delim;
         1: return cfg_quote;
         2: return CHR_CR;
         3: return CHR_LF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Byte that is plain content outside quotes.
   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == cfg_delim || b == cfg_quote || b == CHR_CR || b == CHR_LF);
      return b;
   endfunction

   // Well-formed row: plain or quoted fields, then LF, CR or CR LF.
   task automatic send_row(input int width);
      int len;
      logic [BYTE_W-1:0] b;
      for (int f = 0; f < width; f++) begin
         if (f > 0) send_beat(cfg_delim, 1'b0);
         len = $urandom_range(0, 4);
         if ($urandom_range(0, 2) == 0) begin
            send_beat(cfg_quote, 1'b0);
            repeat (len) begin
               b = any_byte();
               send_beat(b, 1'b0);
               if (b == cfg_quote) send_beat(b, 1'b0);   // escape by doubling
            end
            send_beat(cfg_quote, 1'b0);
         end else begin
            repeat (len) send_beat(plain_byte(), 1'b0);
         end
      end
      case ($urandom_range(0, 2))
         0: send_beat(CHR_LF, 1'b0);
         1: send_beat(CHR_CR, 1'b0);
         default: begin
            send_beat(CHR_CR, 1'b0);
            send_beat(CHR_LF, 1'b0);
         end
      endcase
   endtask

   // Mostly rows of the learned width, some of other widths (count mismatch),
   // and a little noise that breaks rows apart.
   task automatic send_random_stream(input int count);
      int stop_at;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_beat(any_byte(), 1'b0);
         else if ($urandom_range(0, 4) == 0)
            send_row($urandom_range(1, 6));
         else
            send_row(fld_expected);
      end
   endtask

   // Advance to between rows from any phase (needs CR/LF free of register use).
   task automatic finish_row();
      if (rx_phase == PH_QUOTED) send_beat(cfg_quote, 1'b0);
      send_beat(CHR_LF, 1'b0);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset settings: quoting, escapes, breaks, errors and recovery.
   task automatic test_directed_basics();
      // a, quoted field with doubled quote, LF and delimiter inside, empty field, CR LF;
      // this first row teaches a width of three
      send_text("a,\"b\"\"\012,\",\015\012");
      // extreme content bytes, row closed by a lone CR
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_text("\015");
      // plain byte after the closing quote, then a quote in a plain field
      send_text("\"x\"y");
      send_text("z\"");
      // empty row, then a row of two empty fields
      send_text("\012");
      send_text(",\012");
   endtask

   // Register extremes and the precedence rules between the special bytes.
   task automatic test_register_extremes();
      apply_setting(8'h00, 8'hFF, 1'b1);
      send_random_stream(30);
      apply_setting(8'hFF, 8'h00, 1'b0);
      send_random_stream(30);
      // delimiter equal to quote: the delimiter wins
      apply_setting(CHR_PIPE, CHR_PIPE, 1'b1);
      send_text("a|b||\012");
      send_random_stream(20);
      // delimiter on LF, quote on CR: both outrank the row breaks
      apply_setting(CHR_LF, CHR_CR, 1'b1);
      send_text("\015a\012\015\015b\015\012c\015");
      send_random_stream(20);
   endtask

   // Run both sides back to back with no gap on either channel.
   task automatic test_back_to_back();
      apply_setting(CHR_COMMA, CHR_QUOTE, 1'b1);
      no_idle = 1'b1;
      send_random_stream(60);
      wait_drained();
      no_idle = 1'b0;
   endtask

   // Stall the receiver long enough to fill the pipe and stall the request side,
   // then pause the sender until all results are back before resuming.
   task automatic test_backpressure();
      apply_setting(CHR_COMMA, CHR_QUOTE, 1'b0);
      rsp_hold_cycles = HOLD_CYCLES;
      send_random_stream(40);
      wait_drained();
      send_random_stream(20);
   endtask

   task automatic test_random_traffic();
      logic [BYTE_W-1:0] d;
      logic [BYTE_W-1:0] q;
      apply_setting(CHR_COMMA, CHR_QUOTE, 1'b0);
      send_random_stream(60);
      apply_setting(CHR_SEMI, CHR_APOS, 1'b1);
      send_random_stream(60);
      // any delimiter and quote that differ and leave CR/LF alone
      do d = 8'($urandom_range(0, 255)); while (d == CHR_CR || d == CHR_LF);
      do q = 8'($urandom_range(0, 255)); while (q == CHR_CR || q == CHR_LF || q == d);
      apply_setting(d, q, 1'($urandom_range(0, 1)));
      send_random_stream(60);
      apply_setting(CHR_TAB, CHR_QUOTE, 1'b1);
      send_random_stream(60);
   endtask

   // End of data ends the stream for good, so it comes last; the phase it
   // meets is drawn at random.
   task automatic test_end_of_stream();
      apply_setting(CHR_COMMA, CHR_QUOTE, 1'b1);
      finish_row();
      case ($urandom_range(0, 3))
         0: send_text("a,b");        // open row: closes it
         1: send_text("x,\"ab");     // inside quotes: parse error
         2: send_text("a\012");      // between rows
         default: send_text("a\015");  // right after CR
      endcase
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      // every later beat is ignored and reports end of data
      repeat (10) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.in_byte     = '0;
      req_bus.end_of_data = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_DELIMITER;
      csr_bus.data        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_register_extremes();
      test_back_to_back();
      test_backpressure();
      test_random_traffic();
      test_end_of_stream();

      wait_drained();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Response side: draw a stall per beat, or take the long hold a test asked for.
   // ---------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t ns: response beat %0d: %s: got 0x%0h, expected 0x%0h",
               $time, rsp_beat, what, got, want);
   endtask

   // Compare each response beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("beat with nothing expected", 32'd0, 32'd0);
         end else begin
            rsp_want = expected_tokens.pop_front();
            if (rsp_bus.out_byte !== rsp_want.out_byte)
               report_mismatch("out_byte", rsp_bus.out_byte, rsp_want.out_byte);
            if (rsp_bus.byte_valid !== rsp_want.byte_valid)
               report_mismatch("byte_valid", rsp_bus.byte_valid, rsp_want.byte_valid);
            if (rsp_bus.field_end !== rsp_want.field_end)
               report_mismatch("field_end", rsp_bus.field_end, rsp_want.field_end);
            if (rsp_bus.row_end !== rsp_want.row_end)
               report_mismatch("row_end", rsp_bus.row_end, rsp_want.row_end);
            if (rsp_bus.fields_in_row !== rsp_want.fields_in_row)
               report_mismatch("fields_in_row", rsp_bus.fields_in_row, rsp_want.fields_in_row);
            if (rsp_bus.rows_done !== rsp_want.rows_done)
               report_mismatch("rows_done", rsp_bus.rows_done, rsp_want.rows_done);
            if (rsp_bus.status !== rsp_want.status)
               report_mismatch("status", rsp_bus.status, rsp_want.status);
         end
         rsp_beat++;
      end
   end

   // Watchdog: end the run once no channel has moved a beat for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== csv_byte_tokenizer.f =====
design/csvt_pkg.sv
design/csvt_ifs.sv
design/csv_byte_tokenizer.sv
verif/tb.sv
